### hdl/gb3_pkg.sv
// ----------------------------------------------------------------------------
// gb3_pkg
// Shared types and constants of the 3x3 blur with replicated borders.
// ----------------------------------------------------------------------------
package gb3_pkg;

  localparam int unsigned PIX_W       = 8;
  localparam int unsigned SUM_W       = 10;
  localparam int unsigned COEF_W      = 16;
  localparam int unsigned SIZE_W      = 12;
  localparam int unsigned ROW_W       = 12;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned HEIGHT_CAP  = 2048;
  localparam int unsigned QUEUE_DEPTH = 8;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_CENTER  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_EDGE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_CORNER  = 3'd4;

  // register reset values
  localparam logic [SIZE_W-1:0] RST_FRAME_WIDTH  = 12'd1100;
  localparam logic [SIZE_W-1:0] RST_FRAME_HEIGHT = 12'd720;
  localparam logic [COEF_W-1:0] RST_COEF_CENTER  = 16'd13384;
  localparam logic [COEF_W-1:0] RST_COEF_EDGE    = 16'd8113;
  localparam logic [COEF_W-1:0] RST_COEF_CORNER  = 16'd4920;

  typedef struct packed {
    logic [SIZE_W-1:0] frame_width;
    logic [SIZE_W-1:0] frame_height;
    logic [COEF_W-1:0] coef_center;
    logic [COEF_W-1:0] coef_edge;
    logic [COEF_W-1:0] coef_corner;
  } cfg_t;

  // one pending convolution: centre tap and the two tap-group sums
  typedef struct packed {
    logic             last;
    logic [PIX_W-1:0] center;
    logic [SUM_W-1:0] edge_sum;
    logic [SUM_W-1:0] corner_sum;
  } job_t;

  // up to two jobs written into the queue in one cycle, first before second
  typedef struct packed {
    logic push_first;
    logic push_second;
    job_t first;
    job_t second;
  } q_wr_t;

endpackage

### hdl/gb3_ram.sv
// ----------------------------------------------------------------------------
// gb3_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gb3_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/gb3_front.sv
// ----------------------------------------------------------------------------
// gb3_front
// Accepts pixels and drain requests, tracks the frame position, keeps the
// two line stores and the 3x3 window and hands finished windows to the queue.
// ----------------------------------------------------------------------------
module gb3_front #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  gb3_pkg::cfg_t                     cfg_i,
  input  logic                              restart_i,
  input  logic                              s_valid_i,
  output logic                              s_ready_o,
  input  logic [gb3_pkg::PIX_W-1:0]         s_pix_i,
  input  logic                              s_drain_i,
  input  logic [gb3_pkg::QUEUE_CNT_W-1:0]   q_count_i,
  output gb3_pkg::q_wr_t                    q_wr_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned PW = gb3_pkg::PIX_W;
  localparam int unsigned RW = gb3_pkg::ROW_W;

  // window indexed [column][row], column 0 left, row 0 top
  typedef logic [2:0][2:0][PW-1:0] win_t;

  function automatic gb3_pkg::job_t win_job(win_t w, logic last);
    gb3_pkg::job_t j;
    j.last       = last;
    j.center     = w[1][1];
    j.edge_sum   = gb3_pkg::SUM_W'(w[1][0]) + gb3_pkg::SUM_W'(w[0][1]) +
                   gb3_pkg::SUM_W'(w[2][1]) + gb3_pkg::SUM_W'(w[1][2]);
    j.corner_sum = gb3_pkg::SUM_W'(w[0][0]) + gb3_pkg::SUM_W'(w[2][0]) +
                   gb3_pkg::SUM_W'(w[0][2]) + gb3_pkg::SUM_W'(w[2][2]);
    return j;
  endfunction

  logic [31:0]   fw32;
  logic [WW-1:0] w_use;
  logic [RW-1:0] h_use;
  logic [CW-1:0] last_col;

  assign fw32 = 32'(cfg_i.frame_width);

  always_comb begin
    if (fw32 < 32'd2) begin
      w_use = WW'(2);
    end else if (fw32 > 32'(MAX_WIDTH)) begin
      w_use = WW'(MAX_WIDTH);
    end else begin
      w_use = WW'(fw32);
    end
    if (cfg_i.frame_height < 12'd2) begin
      h_use = RW'(2);
    end else if (32'(cfg_i.frame_height) > 32'(gb3_pkg::HEIGHT_CAP)) begin
      h_use = RW'(gb3_pkg::HEIGHT_CAP);
    end else begin
      h_use = RW'(cfg_i.frame_height);
    end
  end

  assign last_col = CW'(w_use - WW'(1));

  // frame position
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          flushing;
  logic          at_last;
  logic          accept;
  logic          take;

  assign flushing = (row_q >= h_use);
  assign at_last  = (col_q == last_col);
  assign accept   = s_valid_i && s_ready_o;
  // drain before the image is complete, or pixels during the flush, are dropped
  assign take     = accept && (flushing == s_drain_i);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (restart_i) begin
      col_d = '0;
      row_d = '0;
    end else if (take) begin
      if (at_last) begin
        col_d = '0;
        row_d = flushing ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  // stage holding the item while the line store read completes
  logic          s1_v_q, s1_v_d;
  logic [CW-1:0] s1_col_q;
  logic [PW-1:0] s1_pix_q;
  logic          s1_flush_q;
  logic          s1_top_mid_q;
  logic          s1_first_q;
  logic          s1_emit1_q;
  logic          s1_emit2_q;
  logic          s1_last_q;

  assign s1_v_d = take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      s1_v_q <= 1'b0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      s1_v_q <= s1_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_col_q     <= col_q;
      s1_pix_q     <= s_pix_i;
      s1_flush_q   <= flushing;
      s1_top_mid_q <= (row_q == RW'(1));
      s1_first_q   <= (col_q == '0);
      s1_emit1_q   <= (row_q != '0) && (col_q != '0);
      s1_emit2_q   <= (row_q != '0) && at_last;
      s1_last_q    <= flushing && at_last;
    end
  end

  // reserve room for the jobs still in flight so the stage never has to wait
  logic [1:0] pend;
  assign pend = s1_v_q ? (2'(s1_emit1_q) + 2'(s1_emit2_q)) : 2'd0;
  assign s_ready_o = (32'(q_count_i) + 32'(pend)) <= (gb3_pkg::QUEUE_DEPTH - 2);

  // line stores: a holds the previous row, b the one above it
  logic [PW-1:0] rd_a;
  logic [PW-1:0] rd_b;
  logic          st_we;

  assign st_we = s1_v_q && !s1_flush_q;

  gb3_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_WIDTH)
  ) u_line_a (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (s1_col_q),
    .wdata_i (s1_pix_q),
    .raddr_i (col_q),
    .rdata_o (rd_a)
  );

  gb3_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_WIDTH)
  ) u_line_b (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (s1_col_q),
    .wdata_i (rd_a),
    .raddr_i (col_q),
    .rdata_o (rd_b)
  );

  // window update
  logic [2:0][PW-1:0] ncol;
  win_t win_q, win_d, win1, win2;

  always_comb begin
    ncol[1] = rd_a;
    ncol[0] = s1_top_mid_q ? rd_a : rd_b;
    ncol[2] = s1_flush_q ? rd_a : s1_pix_q;
    if (s1_first_q) begin
      // left border: the first column is replicated
      win1[0] = ncol;
      win1[1] = ncol;
      win1[2] = ncol;
    end else begin
      win1[0] = win_q[1];
      win1[1] = win_q[2];
      win1[2] = ncol;
    end
    // right border: the last column is replicated for the row's final result
    win2[0] = win1[1];
    win2[1] = win1[2];
    win2[2] = win1[2];
    win_d = win_q;
    if (s1_v_q) begin
      win_d = s1_emit2_q ? win2 : win1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else begin
      win_q <= win_d;
    end
  end

  always_comb begin
    q_wr_o.push_first  = s1_v_q && s1_emit1_q;
    q_wr_o.push_second = s1_v_q && s1_emit2_q;
    q_wr_o.first       = win_job(win1, 1'b0);
    q_wr_o.second      = win_job(win2, s1_last_q);
  end

endmodule

### hdl/gb3_queue.sv
// ----------------------------------------------------------------------------
// gb3_queue
// Short job queue between front and back; takes up to two jobs a cycle and
// gives one.
// ----------------------------------------------------------------------------
module gb3_queue (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  gb3_pkg::q_wr_t                  wr_i,
  input  logic                            pop_i,
  output logic                            valid_o,
  output gb3_pkg::job_t                   job_o,
  output logic [gb3_pkg::QUEUE_CNT_W-1:0] count_o
);

  localparam int unsigned PTRW = gb3_pkg::QUEUE_PTR_W;
  localparam int unsigned CNTW = gb3_pkg::QUEUE_CNT_W;

  gb3_pkg::job_t   mem_q [gb3_pkg::QUEUE_DEPTH];
  logic [PTRW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTRW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0] count_q, count_d;
  logic [PTRW-1:0] addr_second;
  logic            pop;
  logic [1:0]      n_push;

  assign pop         = pop_i && (count_q != '0);
  assign n_push      = 2'(wr_i.push_first) + 2'(wr_i.push_second);
  assign addr_second = wr_ptr_q + PTRW'(wr_i.push_first);

  always_comb begin
    wr_ptr_d = wr_ptr_q + PTRW'(n_push);
    rd_ptr_d = rd_ptr_q + PTRW'(pop);
    count_d  = count_q + CNTW'(n_push) - CNTW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.push_first) begin
      mem_q[wr_ptr_q] <= wr_i.first;
    end
    if (wr_i.push_second) begin
      mem_q[addr_second] <= wr_i.second;
    end
  end

  assign valid_o = (count_q != '0);
  assign job_o   = mem_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

### hdl/gb3_back.sv
// ----------------------------------------------------------------------------
// gb3_back
// Weights the tap groups, sums, truncates and saturates, and holds the
// result in the output register.
// ----------------------------------------------------------------------------
module gb3_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  gb3_pkg::cfg_t             cfg_i,
  input  logic                      job_valid_i,
  input  gb3_pkg::job_t             job_i,
  output logic                      job_pop_o,
  output logic                      m_valid_o,
  input  logic                      m_ready_i,
  output logic [gb3_pkg::PIX_W-1:0] m_pixel_o,
  output logic                      m_last_o
);

  localparam int unsigned PCW = gb3_pkg::COEF_W + gb3_pkg::PIX_W;
  localparam int unsigned PSW = gb3_pkg::COEF_W + gb3_pkg::SUM_W;
  localparam int unsigned TW  = PSW + 2;

  logic           m_v_q, m_v_d;
  logic [PCW-1:0] p_c_q;
  logic [PSW-1:0] p_e_q;
  logic [PSW-1:0] p_k_q;
  logic           m_last_q;

  logic                      o_v_q, o_v_d;
  logic [gb3_pkg::PIX_W-1:0] o_pix_q, o_pix_d;
  logic                      o_last_q;

  logic          o_load;
  logic          m_load;
  logic [TW-1:0] total;
  logic [TW-17:0] whole;

  assign o_load    = m_v_q && (!o_v_q || m_ready_i);
  assign m_load    = !m_v_q || o_load;
  assign job_pop_o = job_valid_i && m_load;

  always_comb begin
    m_v_d = m_v_q;
    if (m_load) begin
      m_v_d = job_valid_i;
    end
    o_v_d = o_v_q;
    if (o_load) begin
      o_v_d = 1'b1;
    end else if (m_ready_i) begin
      o_v_d = 1'b0;
    end
  end

  // drop the Q0.16 fraction and clamp at full white
  always_comb begin
    total   = TW'(p_c_q) + TW'(p_e_q) + TW'(p_k_q);
    whole   = total[TW-1:16];
    o_pix_d = (whole > (TW-16)'(255)) ? 8'hff : whole[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      m_v_q <= m_v_d;
      o_v_q <= o_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      p_c_q    <= PCW'(cfg_i.coef_center) * PCW'(job_i.center);
      p_e_q    <= PSW'(cfg_i.coef_edge) * PSW'(job_i.edge_sum);
      p_k_q    <= PSW'(cfg_i.coef_corner) * PSW'(job_i.corner_sum);
      m_last_q <= job_i.last;
    end
    if (o_load) begin
      o_pix_q  <= o_pix_d;
      o_last_q <= m_last_q;
    end
  end

  assign m_valid_o = o_v_q;
  assign m_pixel_o = o_pix_q;
  assign m_last_o  = o_last_q;

endmodule

### hdl/gaussian_blur_3x3_replicate.sv
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_replicate
// 3x3 symmetric blur of a raster pixel stream with replicated borders.
//
//   channel  | dir | handshake              | payload
//   ---------+-----+------------------------+------------------------------
//   s_axis   | in  | s_axis_tvalid / tready | tdata: pixel_in; tuser: drain
//   m_axis   | out | m_axis_tvalid / tready | tdata: blurred_pixel;
//            |     |                        | tlast: end_of_frame
//   cfg      | in  | cfg_valid_i / ready_o  | cfg_index_i, cfg_data_i
//
// One request per cycle is taken while tready is high; a row's last pixel
// yields two results (none in the top row) and results leave at one per
// cycle while m_axis_tready is high, so a frame of w x h pixels gives
// w x h results over w x (h + 1) requests (one drain row). tready falls
// while the eight-entry job queue could not take the jobs in flight. No
// clearing pass after reset: line stores are not valid until written.
// ----------------------------------------------------------------------------
module gaussian_blur_3x3_replicate #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // s_axis_tdata: [7:0] pixel_in
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,
  // s_axis_tuser: [0] drain
  input  logic [0:0]                         s_axis_tuser,
  // m_axis_tdata: [7:0] blurred_pixel
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [7:0]                         m_axis_tdata,
  output logic                               m_axis_tlast,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [gb3_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [gb3_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  gb3_pkg::cfg_t cfg_q, cfg_d;
  logic          restart;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d   = cfg_q;
    restart = 1'b0;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        gb3_pkg::CFG_FRAME_WIDTH: begin
          cfg_d.frame_width = cfg_data_i[gb3_pkg::SIZE_W-1:0];
          restart           = 1'b1;
        end
        gb3_pkg::CFG_FRAME_HEIGHT: begin
          cfg_d.frame_height = cfg_data_i[gb3_pkg::SIZE_W-1:0];
          restart            = 1'b1;
        end
        gb3_pkg::CFG_COEF_CENTER: begin
          cfg_d.coef_center = cfg_data_i;
        end
        gb3_pkg::CFG_COEF_EDGE: begin
          cfg_d.coef_edge = cfg_data_i;
        end
        gb3_pkg::CFG_COEF_CORNER: begin
          cfg_d.coef_corner = cfg_data_i;
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width  <= gb3_pkg::RST_FRAME_WIDTH;
      cfg_q.frame_height <= gb3_pkg::RST_FRAME_HEIGHT;
      cfg_q.coef_center  <= gb3_pkg::RST_COEF_CENTER;
      cfg_q.coef_edge    <= gb3_pkg::RST_COEF_EDGE;
      cfg_q.coef_corner  <= gb3_pkg::RST_COEF_CORNER;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  gb3_pkg::q_wr_t                  q_wr;
  logic [gb3_pkg::QUEUE_CNT_W-1:0] q_count;
  logic                            q_valid;
  gb3_pkg::job_t                   q_job;
  logic                            q_pop;

  gb3_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .restart_i (restart),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_pix_i   (s_axis_tdata),
    .s_drain_i (s_axis_tuser[0]),
    .q_count_i (q_count),
    .q_wr_o    (q_wr)
  );

  gb3_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (q_job),
    .count_o (q_count)
  );

  gb3_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (q_valid),
    .job_i       (q_job),
    .job_pop_o   (q_pop),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_pixel_o   (m_axis_tdata),
    .m_last_o    (m_axis_tlast)
  );

endmodule
